[hdl/bzcd_pkg.sv]
// Shared types, constants and step tables for the back-EMF zero-crossing detector.
// Used by bzcd_bin_div, bemf_zero_cross_detector_unit and the testbench; no dependencies.
`default_nettype none

package bzcd_pkg;

    // Sizes
    localparam int SAMPLE_BITS = 12;
    localparam int HIST_BINS   = 10;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int LVL_W       = 12;
    localparam int CNT4_W      = 4;
    localparam int TIME_W      = 32;
    localparam int SEC_W       = 3;
    localparam int BIN_W       = 4;
    localparam int NUM_STEPS   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    // diff vs deadband compare width, level compare width
    localparam int CMP_W     = ((DIFF_W > LVL_W) ? DIFF_W : LVL_W) + 1;
    localparam int SAT_CMP_W = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W;

    // Bin divider: quotient below HIST_BINS needs QBITS bits
    localparam int QBITS  = $clog2(HIST_BINS);
    localparam int MUL_W  = TIME_W + QBITS;
    localparam int QCNT_W = $clog2(QBITS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH  = 3'd4;

    // Register reset values
    localparam logic [LVL_W-1:0]  DEADBAND_RST = 12'd8;
    localparam logic [CNT4_W-1:0] CONFIRM_RST  = 4'd3;
    localparam logic [CNT4_W-1:0] BLANK_RST    = 4'd2;
    localparam logic [LVL_W-1:0]  SAT_LOW_RST  = 12'd50;
    localparam logic [LVL_W-1:0]  SAT_HIGH_RST = 12'd4045;

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COMMUT = 1'b1;

    // Arm modes
    localparam logic [1:0] ARM_NONE = 2'd0;
    localparam logic [1:0] ARM_RISE = 2'd1;
    localparam logic [1:0] ARM_FALL = 2'd2;

    // Phase codes
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
    } bzcd_div_req_t;

    typedef struct packed {
        logic             done;
        logic [BIN_W-1:0] bin;
    } bzcd_div_rsp_t;

    // Step table: positive phase
    function automatic logic [1:0] pos_phase(input logic [SEC_W-1:0] sec);
        logic [1:0] ph;
        unique case (sec)
            3'd0, 3'd1: ph = PH_A;
            3'd2, 3'd3: ph = PH_B;
            3'd4, 3'd5: ph = PH_C;
            default:    ph = PH_A;
        endcase
        return ph;
    endfunction

    // Step table: floating phase
    function automatic logic [1:0] flt_phase(input logic [SEC_W-1:0] sec);
        logic [1:0] ph;
        unique case (sec)
            3'd0:    ph = PH_C;
            3'd1:    ph = PH_B;
            3'd2:    ph = PH_A;
            3'd3:    ph = PH_C;
            3'd4:    ph = PH_B;
            3'd5:    ph = PH_A;
            default: ph = PH_C;
        endcase
        return ph;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_phase(
        input logic [1:0]             ph,
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic [SAMPLE_BITS-1:0] v;
        unique case (ph)
            PH_A:    v = a;
            PH_B:    v = b;
            default: v = c;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/bzcd_bin_div.sv]
// Delay-to-period bin unit: min(floor(delay * HIST_BINS / period), HIST_BINS - 1), 0 for period 0.
// Bit-serial restoring division, one quotient bit per cycle. Uses bzcd_pkg.
`default_nettype none

module bzcd_bin_div (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bzcd_pkg::bzcd_div_req_t req,
    output bzcd_pkg::bzcd_div_rsp_t      rsp
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CMP  = 2'd1;
    localparam logic [1:0] D_DIV  = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [bzcd_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            done_reg, done_next;

    logic [bzcd_pkg::MUL_W-1:0]      num_reg, num_next;
    logic [bzcd_pkg::MUL_W-1:0]      lim_reg, lim_next;
    logic [bzcd_pkg::TIME_W-1:0]     per_reg, per_next;
    logic [bzcd_pkg::TIME_W-1:0]     rem_reg, rem_next;
    logic [bzcd_pkg::QBITS-1:0]      sh_reg, sh_next;
    logic [bzcd_pkg::QBITS-1:0]      q_reg, q_next;
    logic [bzcd_pkg::BIN_W-1:0]      bin_reg, bin_next;

    logic [bzcd_pkg::TIME_W:0]       trial;
    logic [bzcd_pkg::TIME_W:0]       trial_sub;
    logic                            ge;

    assign trial     = {rem_reg, sh_reg[bzcd_pkg::QBITS-1]};
    assign trial_sub = trial - {1'b0, per_reg};
    assign ge        = trial >= {1'b0, per_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        lim_next   = lim_reg;
        per_next   = per_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        bin_next   = bin_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    num_next   = bzcd_pkg::MUL_W'(req.delay)
                                 * bzcd_pkg::MUL_W'(bzcd_pkg::HIST_BINS);
                    lim_next   = bzcd_pkg::MUL_W'(req.period)
                                 * bzcd_pkg::MUL_W'(bzcd_pkg::HIST_BINS);
                    per_next   = req.period;
                    state_next = D_CMP;
                end
            end
            D_CMP:
            begin
                // below the cap the quotient fits QBITS bits, so the top
                // part of the numerator is already smaller than the period
                if (per_reg == '0)
                begin
                    bin_next   = '0;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else if (num_reg >= lim_reg)
                begin
                    bin_next   = bzcd_pkg::BIN_W'(bzcd_pkg::HIST_BINS - 1);
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    rem_next   = num_reg[bzcd_pkg::MUL_W-1:bzcd_pkg::QBITS];
                    sh_next    = num_reg[bzcd_pkg::QBITS-1:0];
                    q_next     = '0;
                    cnt_next   = bzcd_pkg::QCNT_W'(bzcd_pkg::QBITS);
                    state_next = D_DIV;
                end
            end
            D_DIV:
            begin
                rem_next = ge ? trial_sub[bzcd_pkg::TIME_W-1:0]
                              : trial[bzcd_pkg::TIME_W-1:0];
                sh_next  = sh_reg << 1;
                q_next   = bzcd_pkg::QBITS'({q_reg, ge});
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == bzcd_pkg::QCNT_W'(1))
                begin
                    bin_next   = bzcd_pkg::BIN_W'(q_next);
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        lim_reg <= lim_next;
        per_reg <= per_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        bin_reg <= bin_next;
    end

    assign rsp.done = done_reg;
    assign rsp.bin  = bin_reg;

endmodule

`default_nettype wire

[hdl/bemf_zero_cross_detector_unit.sv]
// Top level of the back-EMF zero-crossing detector for six-step drives.
// Depends on bzcd_pkg and bzcd_bin_div.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  in      | in_valid / in_stall (out)  | opcode, phase_{a,b,c}_sample, time_now_us,
//          |                            | sector_index, sector_period_us
//  out     | out_valid / out_stall (in) | floating_diff, was_blanked, low/high_saturated,
//          |                            | crossing_found/falling, crossing_delay_us, delay_bin
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item at a time. An item without a confirmed crossing goes straight from S_IDLE to
// S_PUSH; a confirming item waits in S_BIN for the bit-serial bin divider, which
// produces one quotient bit per cycle.
// The output register holds one result; the next item is taken while it waits.
// Reset loads the register defaults and clears all sector state; no clearing pass.
`default_nettype none

module bemf_zero_cross_detector_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                opcode,
    input  wire logic [bzcd_pkg::SAMPLE_BITS-1:0]    phase_a_sample,
    input  wire logic [bzcd_pkg::SAMPLE_BITS-1:0]    phase_b_sample,
    input  wire logic [bzcd_pkg::SAMPLE_BITS-1:0]    phase_c_sample,
    input  wire logic [bzcd_pkg::TIME_W-1:0]         time_now_us,
    input  wire logic [bzcd_pkg::SEC_W-1:0]          sector_index,
    input  wire logic [bzcd_pkg::TIME_W-1:0]         sector_period_us,

    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [bzcd_pkg::DIFF_W-1:0]       floating_diff,
    output logic                                     was_blanked,
    output logic                                     low_saturated,
    output logic                                     high_saturated,
    output logic                                     crossing_found,
    output logic                                     crossing_falling,
    output logic [bzcd_pkg::TIME_W-1:0]              crossing_delay_us,
    output logic [bzcd_pkg::BIN_W-1:0]               delay_bin,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bzcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bzcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BIN  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    // configuration
    logic [bzcd_pkg::LVL_W-1:0]     deadband_reg;
    logic [bzcd_pkg::CNT4_W-1:0]    confirm_reg;
    logic [bzcd_pkg::CNT4_W-1:0]    blank_reg;
    logic [bzcd_pkg::LVL_W-1:0]     sat_low_reg;
    logic [bzcd_pkg::LVL_W-1:0]     sat_high_reg;

    // sector state
    logic [1:0]                     state_reg, state_next;
    logic [bzcd_pkg::SEC_W-1:0]     cur_sector_reg, cur_sector_next;
    logic [bzcd_pkg::TIME_W-1:0]    sec_len_reg, sec_len_next;
    logic [bzcd_pkg::TIME_W-1:0]    sec_start_reg, sec_start_next;
    logic [bzcd_pkg::CNT4_W-1:0]    blank_left_reg, blank_left_next;
    logic [1:0]                     arm_mode_reg, arm_mode_next;
    logic                           sector_done_reg, sector_done_next;
    logic [bzcd_pkg::CNT4_W-1:0]    qual_run_reg, qual_run_next;

    // result staging
    logic signed [bzcd_pkg::DIFF_W-1:0] res_diff_reg, res_diff_next;
    logic                           res_blank_reg, res_blank_next;
    logic                           res_low_reg, res_low_next;
    logic                           res_high_reg, res_high_next;
    logic                           res_found_reg, res_found_next;
    logic                           res_fall_reg, res_fall_next;
    logic [bzcd_pkg::TIME_W-1:0]    res_delay_reg, res_delay_next;
    logic [bzcd_pkg::BIN_W-1:0]     res_bin_reg, res_bin_next;

    // output register
    logic                           out_valid_reg;
    logic signed [bzcd_pkg::DIFF_W-1:0] out_diff_reg;
    logic                           out_blank_reg;
    logic                           out_low_reg;
    logic                           out_high_reg;
    logic                           out_found_reg;
    logic                           out_fall_reg;
    logic [bzcd_pkg::TIME_W-1:0]    out_delay_reg;
    logic [bzcd_pkg::BIN_W-1:0]     out_bin_reg;

    logic                           accept;
    logic                           push;
    logic                           cfg_we;

    logic [bzcd_pkg::SAMPLE_BITS-1:0]  flt_val;
    logic [bzcd_pkg::SAMPLE_BITS-1:0]  pos_val;
    logic signed [bzcd_pkg::DIFF_W-1:0] diff;
    logic signed [bzcd_pkg::CMP_W-1:0] diff_c;
    logic signed [bzcd_pkg::CMP_W-1:0] db_c;
    logic                           at_neg;
    logic                           at_pos;
    logic [bzcd_pkg::CNT4_W-1:0]    need;
    logic                           qual_ok;
    logic [bzcd_pkg::CNT4_W-1:0]    qual_new;
    logic [bzcd_pkg::SEC_W-1:0]     idx_wrap;
    logic [bzcd_pkg::TIME_W-1:0]    delay_now;

    bzcd_pkg::bzcd_div_req_t        div_req;
    bzcd_pkg::bzcd_div_rsp_t        div_rsp;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign push      = (state_reg == S_PUSH) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // diff = floating - positive/2
    assign flt_val = bzcd_pkg::pick_phase(bzcd_pkg::flt_phase(cur_sector_reg),
                                          phase_a_sample, phase_b_sample, phase_c_sample);
    assign pos_val = bzcd_pkg::pick_phase(bzcd_pkg::pos_phase(cur_sector_reg),
                                          phase_a_sample, phase_b_sample, phase_c_sample);
    assign diff    = $signed(bzcd_pkg::DIFF_W'(flt_val) - bzcd_pkg::DIFF_W'(pos_val >> 1));
    assign diff_c  = bzcd_pkg::CMP_W'(diff);
    assign db_c    = $signed(bzcd_pkg::CMP_W'(deadband_reg));
    assign at_neg  = diff_c <= -db_c;
    assign at_pos  = diff_c >= db_c;

    assign need     = (confirm_reg == '0) ? bzcd_pkg::CNT4_W'(1) : confirm_reg;
    assign qual_ok  = (arm_mode_reg == bzcd_pkg::ARM_RISE) ? at_pos : at_neg;
    assign qual_new = !qual_ok ? '0
                    : (qual_run_reg < need) ? qual_run_reg + 1'b1 : qual_run_reg;

    assign idx_wrap  = (sector_index >= bzcd_pkg::SEC_W'(bzcd_pkg::NUM_STEPS))
                     ? sector_index - bzcd_pkg::SEC_W'(bzcd_pkg::NUM_STEPS)
                     : sector_index;
    assign delay_now = time_now_us - sec_start_reg;

    always_comb
    begin
        state_next       = state_reg;
        cur_sector_next  = cur_sector_reg;
        sec_len_next     = sec_len_reg;
        sec_start_next   = sec_start_reg;
        blank_left_next  = blank_left_reg;
        arm_mode_next    = arm_mode_reg;
        sector_done_next = sector_done_reg;
        qual_run_next    = qual_run_reg;
        res_diff_next    = res_diff_reg;
        res_blank_next   = res_blank_reg;
        res_low_next     = res_low_reg;
        res_high_next    = res_high_reg;
        res_found_next   = res_found_reg;
        res_fall_next    = res_fall_reg;
        res_delay_next   = res_delay_reg;
        res_bin_next     = res_bin_reg;
        div_req.start    = 1'b0;
        div_req.delay    = delay_now;
        div_req.period   = sec_len_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_diff_next  = '0;
                    res_blank_next = 1'b0;
                    res_low_next   = 1'b0;
                    res_high_next  = 1'b0;
                    res_found_next = 1'b0;
                    res_fall_next  = 1'b0;
                    res_delay_next = '0;
                    res_bin_next   = '0;
                    state_next     = S_PUSH;
                    if (opcode == bzcd_pkg::OP_COMMUT)
                    begin
                        cur_sector_next  = idx_wrap;
                        sec_start_next   = time_now_us;
                        sec_len_next     = sector_period_us;
                        arm_mode_next    = bzcd_pkg::ARM_NONE;
                        sector_done_next = 1'b0;
                        qual_run_next    = '0;
                        blank_left_next  = blank_reg;
                    end
                    else
                    begin
                        res_diff_next = diff;
                        if (blank_left_reg != '0)
                        begin
                            blank_left_next = blank_left_reg - 1'b1;
                            res_blank_next  = 1'b1;
                        end
                        else
                        begin
                            res_low_next  = bzcd_pkg::SAT_CMP_W'(flt_val)
                                            <= bzcd_pkg::SAT_CMP_W'(sat_low_reg);
                            res_high_next = bzcd_pkg::SAT_CMP_W'(flt_val)
                                            >= bzcd_pkg::SAT_CMP_W'(sat_high_reg);
                            if (sector_done_reg)
                            begin
                                // one crossing per sector
                            end
                            else if (arm_mode_reg == bzcd_pkg::ARM_NONE)
                            begin
                                if (at_neg)
                                begin
                                    arm_mode_next = bzcd_pkg::ARM_RISE;
                                    qual_run_next = '0;
                                end
                                else if (at_pos)
                                begin
                                    arm_mode_next = bzcd_pkg::ARM_FALL;
                                    qual_run_next = '0;
                                end
                            end
                            else if (qual_new >= need)
                            begin
                                qual_run_next    = '0;
                                sector_done_next = 1'b1;
                                res_found_next   = 1'b1;
                                res_fall_next    = (arm_mode_reg == bzcd_pkg::ARM_FALL);
                                res_delay_next   = delay_now;
                                div_req.start    = 1'b1;
                                state_next       = S_BIN;
                            end
                            else
                            begin
                                qual_run_next = qual_new;
                            end
                        end
                    end
                end
            end
            S_BIN:
            begin
                if (div_rsp.done)
                begin
                    res_bin_next = div_rsp.bin;
                    state_next   = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    bzcd_bin_div u_bin_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg    <= bzcd_pkg::DEADBAND_RST;
            confirm_reg     <= bzcd_pkg::CONFIRM_RST;
            blank_reg       <= bzcd_pkg::BLANK_RST;
            sat_low_reg     <= bzcd_pkg::SAT_LOW_RST;
            sat_high_reg    <= bzcd_pkg::SAT_HIGH_RST;
            state_reg       <= S_IDLE;
            cur_sector_reg  <= '0;
            sec_len_reg     <= '0;
            sec_start_reg   <= '0;
            blank_left_reg  <= '0;
            arm_mode_reg    <= bzcd_pkg::ARM_NONE;
            sector_done_reg <= 1'b0;
            qual_run_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bzcd_pkg::CFG_DEADBAND: deadband_reg <= cfg_data;
                    bzcd_pkg::CFG_CONFIRM:  confirm_reg  <= cfg_data[bzcd_pkg::CNT4_W-1:0];
                    bzcd_pkg::CFG_BLANK:    blank_reg    <= cfg_data[bzcd_pkg::CNT4_W-1:0];
                    bzcd_pkg::CFG_SAT_LOW:  sat_low_reg  <= cfg_data;
                    bzcd_pkg::CFG_SAT_HIGH: sat_high_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            state_reg       <= state_next;
            cur_sector_reg  <= cur_sector_next;
            sec_len_reg     <= sec_len_next;
            sec_start_reg   <= sec_start_next;
            blank_left_reg  <= blank_left_next;
            arm_mode_reg    <= arm_mode_next;
            sector_done_reg <= sector_done_next;
            qual_run_reg    <= qual_run_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_diff_reg  <= res_diff_next;
        res_blank_reg <= res_blank_next;
        res_low_reg   <= res_low_next;
        res_high_reg  <= res_high_next;
        res_found_reg <= res_found_next;
        res_fall_reg  <= res_fall_next;
        res_delay_reg <= res_delay_next;
        res_bin_reg   <= res_bin_next;
        if (push)
        begin
            out_diff_reg  <= res_diff_reg;
            out_blank_reg <= res_blank_reg;
            out_low_reg   <= res_low_reg;
            out_high_reg  <= res_high_reg;
            out_found_reg <= res_found_reg;
            out_fall_reg  <= res_fall_reg;
            out_delay_reg <= res_delay_reg;
            out_bin_reg   <= res_bin_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign floating_diff     = out_diff_reg;
    assign was_blanked       = out_blank_reg;
    assign low_saturated     = out_low_reg;
    assign high_saturated    = out_high_reg;
    assign crossing_found    = out_found_reg;
    assign crossing_falling  = out_fall_reg;
    assign crossing_delay_us = out_delay_reg;
    assign delay_bin         = out_bin_reg;

    a_cross_unblanked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && crossing_found |-> !was_blanked)
        else $error("crossing reported on a blanked item");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> delay_bin <= bzcd_pkg::BIN_W'(bzcd_pkg::HIST_BINS - 1))
        else $error("delay bin above top bin");

    a_no_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !crossing_found |->
            !crossing_falling && crossing_delay_us == '0 && delay_bin == '0)
        else $error("crossing fields set without a crossing");

    a_div_done_in_bin: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_BIN)
        else $error("bin divider finished outside bin wait");

endmodule

`default_nettype wire

[tb/zero_cross_checker.sv]
`timescale 1ns / 100ps
// Checker for the back-EMF zero-crossing detector: tracks sector state, predicts
// each scan result and compares it with the output channel. Depends on bzcd_pkg.
module zero_cross_checker
    import bzcd_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic                       opcode,
    input  wire logic [SAMPLE_BITS-1:0]     phase_a_sample,
    input  wire logic [SAMPLE_BITS-1:0]     phase_b_sample,
    input  wire logic [SAMPLE_BITS-1:0]     phase_c_sample,
    input  wire logic [TIME_W-1:0]          time_now_us,
    input  wire logic [SEC_W-1:0]           sector_index,
    input  wire logic [TIME_W-1:0]          sector_period_us,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic signed [DIFF_W-1:0]   floating_diff,
    input  wire logic                       was_blanked,
    input  wire logic                       low_saturated,
    input  wire logic                       high_saturated,
    input  wire logic                       crossing_found,
    input  wire logic                       crossing_falling,
    input  wire logic [TIME_W-1:0]          crossing_delay_us,
    input  wire logic [BIN_W-1:0]           delay_bin,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    output int                              pending,
    output int                              fails
);

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic                     blanked;
        logic                     sat_lo;
        logic                     sat_hi;
        logic                     found;
        logic                     falling;
        logic [TIME_W-1:0]        delay;
        logic [BIN_W-1:0]         bin;
    } scan_result_t;

    scan_result_t expected_scans[$];

    // register copies
    logic [LVL_W-1:0]  deadband;
    logic [CNT4_W-1:0] confirm_cnt;
    logic [CNT4_W-1:0] blank_cnt;
    logic [LVL_W-1:0]  sat_lo_level;
    logic [LVL_W-1:0]  sat_hi_level;

    // sector state
    logic [SEC_W-1:0]  sector;
    logic [TIME_W-1:0] sector_start;
    logic [TIME_W-1:0] sector_len;
    logic [CNT4_W-1:0] blank_left;
    logic [CNT4_W-1:0] run_len;
    logic [1:0]        arm;
    logic              done_flag;

    int mismatches = 0;

    function automatic scan_result_t predict_scan(
        input logic                   op,
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c,
        input logic [TIME_W-1:0]      now,
        input logic [SEC_W-1:0]       idx,
        input logic [TIME_W-1:0]      period
    );
        scan_result_t r;
        logic [SAMPLE_BITS-1:0] flt;
        logic [SAMPLE_BITS-1:0] pos;
        logic [TIME_W-1:0] dly;
        logic [63:0] q;
        logic hit;
        int d;
        int db;
        int need;
        r = '0;
        if (op == OP_COMMUT) begin
            sector       = (idx >= 3'd6) ? idx - 3'd6 : idx;
            sector_start = now;
            sector_len   = period;
            arm          = ARM_NONE;
            done_flag    = 1'b0;
            run_len      = '0;
            blank_left   = blank_cnt;
            return r;
        end
        case (sector)
            3'd0:    begin pos = a; flt = c; end
            3'd1:    begin pos = a; flt = b; end
            3'd2:    begin pos = b; flt = a; end
            3'd3:    begin pos = b; flt = c; end
            3'd4:    begin pos = c; flt = b; end
            default: begin pos = c; flt = a; end
        endcase
        d = int'(flt) - int'(pos >> 1);
        r.diff = d[DIFF_W-1:0];
        if (blank_left != '0) begin
            blank_left = blank_left - 1'b1;
            r.blanked = 1'b1;
            return r;
        end
        r.sat_lo = (flt <= sat_lo_level);
        r.sat_hi = (flt >= sat_hi_level);
        if (done_flag)
            return r;
        db = int'(deadband);
        if (arm == ARM_NONE) begin
            if (d <= -db) begin
                arm = ARM_RISE;
                run_len = '0;
            end else if (d >= db) begin
                arm = ARM_FALL;
                run_len = '0;
            end
            return r;
        end
        // a zero confirm count acts as one
        need = (confirm_cnt == '0) ? 1 : int'(confirm_cnt);
        hit = (arm == ARM_RISE) ? (d >= db) : (d <= -db);
        if (!hit)
            run_len = '0;
        else if (run_len < need)
            run_len = run_len + 1'b1;
        if (run_len >= need) begin
            dly = now - sector_start;
            run_len = '0;
            done_flag = 1'b1;
            q = '0;
            if (sector_len != '0) begin
                q = (64'(dly) * HIST_BINS) / 64'(sector_len);
                if (q >= HIST_BINS)
                    q = HIST_BINS - 1;
            end
            r.found   = 1'b1;
            r.falling = (arm == ARM_FALL);
            r.delay   = dly;
            r.bin     = q[BIN_W-1:0];
        end
        return r;
    endfunction

    task automatic log_failure(input string what, input scan_result_t want,
                               input scan_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s (expected/actual): diff %0d/%0d blank %b/%b lo %b/%b hi %b/%b",
                     $time, what, $signed(want.diff), $signed(got.diff),
                     want.blanked, got.blanked, want.sat_lo, got.sat_lo,
                     want.sat_hi, got.sat_hi);
            $display("    found %b/%b falling %b/%b delay %0d/%0d bin %0d/%0d",
                     want.found, got.found, want.falling, got.falling,
                     want.delay, got.delay, want.bin, got.bin);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        scan_result_t got;
        scan_result_t want;
        logic bad;
        if (!rst_n) begin
            deadband     = DEADBAND_RST;
            confirm_cnt  = CONFIRM_RST;
            blank_cnt    = BLANK_RST;
            sat_lo_level = SAT_LOW_RST;
            sat_hi_level = SAT_HIGH_RST;
            sector       = '0;
            sector_start = '0;
            sector_len   = '0;
            blank_left   = '0;
            run_len      = '0;
            arm          = ARM_NONE;
            done_flag    = 1'b0;
            expected_scans.delete();
            pending <= 0;
            fails   <= mismatches;
        end else begin
            // results first: an item taken at this edge cannot be the one leaving
            if (out_valid && !out_stall) begin
                got = {floating_diff, was_blanked, low_saturated, high_saturated,
                       crossing_found, crossing_falling, crossing_delay_us, delay_bin};
                if (expected_scans.size() == 0) begin
                    log_failure("result with nothing expected", '0, got);
                end else begin
                    want = expected_scans.pop_front();
                    bad = (got.diff !== want.diff) || (got.blanked !== want.blanked)
                       || (got.sat_lo !== want.sat_lo) || (got.sat_hi !== want.sat_hi)
                       || (got.found !== want.found) || (got.falling !== want.falling)
                       || (got.delay !== want.delay) || (got.bin !== want.bin);
                    if (bad)
                        log_failure("result mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEADBAND: deadband     = cfg_data[LVL_W-1:0];
                    CFG_CONFIRM:  confirm_cnt  = cfg_data[CNT4_W-1:0];
                    CFG_BLANK:    blank_cnt    = cfg_data[CNT4_W-1:0];
                    CFG_SAT_LOW:  sat_lo_level = cfg_data[LVL_W-1:0];
                    CFG_SAT_HIGH: sat_hi_level = cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_scans.push_back(predict_scan(opcode, phase_a_sample, phase_b_sample,
                                                      phase_c_sample, time_now_us, sector_index,
                                                      sector_period_us));
            pending <= expected_scans.size();
            fails   <= mismatches;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the back-EMF zero-crossing detector: clock, reset, scan and
// commutation stimulus, output stalls, register settings and the verdict.
// Depends on bzcd_pkg, bemf_zero_cross_detector_unit and zero_cross_checker.
module tb;
    import bzcd_pkg::*;

    localparam int     CLK_HALF_NS = 10;
    localparam longint LIMIT_NS    = 64'd20_000_000;
    localparam int     MAX_LVL     = (1 << SAMPLE_BITS) - 1;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       opcode;
    logic [SAMPLE_BITS-1:0]     phase_a_sample;
    logic [SAMPLE_BITS-1:0]     phase_b_sample;
    logic [SAMPLE_BITS-1:0]     phase_c_sample;
    logic [TIME_W-1:0]          time_now_us;
    logic [SEC_W-1:0]           sector_index;
    logic [TIME_W-1:0]          sector_period_us;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DIFF_W-1:0]   floating_diff;
    logic                       was_blanked;
    logic                       low_saturated;
    logic                       high_saturated;
    logic                       crossing_found;
    logic                       crossing_falling;
    logic [TIME_W-1:0]          crossing_delay_us;
    logic [BIN_W-1:0]           delay_bin;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    int                         pending;
    int                         fails;

    logic [TIME_W-1:0] clock_us;
    int   cur_db;
    int   cur_need;
    int   cur_blank;
    int   send_calm;
    int   sent;
    logic hold_kick;

    bemf_zero_cross_detector_unit dut (.*);
    zero_cross_checker chk (.*);

    always begin
        clk = 1'b0;
        #CLK_HALF_NS;
        clk = 1'b1;
        #CLK_HALF_NS;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb NOT OK");
        $finish;
    end

    // mostly short gaps, a few long ones, now and then a run with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // output stalls, with random long hold-offs and one longer hold-off once the random part starts
    initial begin : stall_gen
        int hold_left;
        int stall_left;
        int free_left;
        int calm;
        logic hold_done;
        out_stall = 1'b0;
        hold_left = 0;
        stall_left = 0;
        free_left = 0;
        calm = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_kick && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left == 0 && stall_left == 0 && free_left == 0) begin
                stall_left = pick_gap(calm);
                free_left = $urandom_range(1, 8);
                if ($urandom_range(0, 499) == 0)
                    hold_left = $urandom_range(100, 300);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                free_left--;
                out_stall <= 1'b0;
            end
        end
    end

    // valid stays high after the item when no gap follows
    task automatic send(input logic op, input logic [SAMPLE_BITS-1:0] a,
                        input logic [SAMPLE_BITS-1:0] b, input logic [SAMPLE_BITS-1:0] c,
                        input logic [TIME_W-1:0] t, input logic [SEC_W-1:0] idx,
                        input logic [TIME_W-1:0] per);
        int gap;
        in_valid         <= 1'b1;
        opcode           <= op;
        phase_a_sample   <= a;
        phase_b_sample   <= b;
        phase_c_sample   <= c;
        time_now_us      <= t;
        sector_index     <= idx;
        sector_period_us <= per;
        do @(posedge clk); while (in_stall);
        sent++;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    // waits for the block to drain, then writes every register
    task automatic apply_setting(input int db, input int cf, input int bl,
                                 input int lo, input int hi);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (12) @(posedge clk);
        write_reg(CFG_DEADBAND, db);
        // upper data bits are junk for the 4-bit registers
        write_reg(CFG_CONFIRM, cf | ($urandom_range(0, 255) << 4));
        write_reg(CFG_BLANK, bl | ($urandom_range(0, 255) << 4));
        write_reg(CFG_SAT_LOW, lo);
        write_reg(CFG_SAT_HIGH, hi);
        write_reg(CFG_UNUSED, $urandom_range(0, MAX_LVL));
        cfg_valid <= 1'b0;
        @(posedge clk);
        cur_db = db;
        cur_need = (cf == 0) ? 1 : cf;
        cur_blank = bl;
    endtask

    function automatic void place(input int sec, input int p, input int f, input int o,
                                  output logic [SAMPLE_BITS-1:0] a,
                                  output logic [SAMPLE_BITS-1:0] b,
                                  output logic [SAMPLE_BITS-1:0] c);
        case (sec)
            0:       begin a = p; c = f; b = o; end
            1:       begin a = p; b = f; c = o; end
            2:       begin b = p; a = f; c = o; end
            3:       begin b = p; c = f; a = o; end
            4:       begin c = p; b = f; a = o; end
            default: begin c = p; a = f; b = o; end
        endcase
    endfunction

    // commutation, then a floating trace that swings across half the positive level
    task automatic run_sector(input int cut);
        logic [SEC_W-1:0] idx;
        logic [TIME_W-1:0] per;
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
        logic [SAMPLE_BITS-1:0] c;
        int sec, lvl, n, m, p, amp, dir, nz, k, f, r;
        idx = $urandom_range(0, 7);
        sec = (idx >= 6) ? int'(idx) - 6 : int'(idx);
        lvl = cur_need + $urandom_range(1, 2 * cur_need + 8);
        n = cur_blank + lvl;
        if (n > cut)
            n = cut;
        r = $urandom_range(0, 99);
        if (r < 5)
            per = '0;
        else if (r < 10)
            per = $urandom_range(1, 20);
        else if (r < 15)
            per = $urandom();
        else
            per = (cur_blank + lvl) * $urandom_range(20, 70);
        clock_us = clock_us + $urandom_range(1, 100);
        send(OP_COMMUT, $urandom_range(0, MAX_LVL), $urandom_range(0, MAX_LVL),
             $urandom_range(0, MAX_LVL), clock_us, idx, per);
        p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LVL)
                                        : $urandom_range(1500, MAX_LVL);
        dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
        amp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cur_db)
                                          : cur_db + $urandom_range(1, 400);
        nz = $urandom_range(0, 20);
        m = $urandom_range(1, lvl - cur_need);
        for (k = 0; k < n; k++) begin
            clock_us = clock_us + $urandom_range(1, 60);
            if (k < cur_blank)
                f = $urandom_range(0, MAX_LVL);
            else if ($urandom_range(0, 11) == 0)
                f = p / 2;  // glitch into the deadband, breaks the run when the deadband is nonzero
            else
                f = p / 2 + dir * ((k - cur_blank < m) ? amp : -amp)
                    + int'($urandom_range(0, 2 * nz)) - nz;
            if (f < 0)
                f = 0;
            else if (f > MAX_LVL)
                f = MAX_LVL;
            place(sec, p, f, $urandom_range(0, MAX_LVL), a, b, c);
            send(OP_SAMPLE, a, b, c, clock_us, $urandom_range(0, 7), $urandom());
        end
    endtask

    task automatic random_phase(input int quota);
        int start;
        int r;
        start = sent;
        while (sent - start < quota) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                run_sector(1000);
            else if (r < 90)
                send($urandom_range(0, 1), $urandom_range(0, MAX_LVL),
                     $urandom_range(0, MAX_LVL), $urandom_range(0, MAX_LVL),
                     $urandom(), $urandom_range(0, 7), $urandom());
            else
                run_sector($urandom_range(1, 4));
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        opcode           = OP_SAMPLE;
        phase_a_sample   = '0;
        phase_b_sample   = '0;
        phase_c_sample   = '0;
        time_now_us      = '0;
        sector_index     = '0;
        sector_period_us = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_DEADBAND;
        cfg_data         = '0;
        hold_kick        = 1'b0;
        send_calm        = 0;
        sent             = 0;
        cur_db           = DEADBAND_RST;
        cur_need         = CONFIRM_RST;
        cur_blank        = BLANK_RST;
        clock_us         = $urandom();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any commutation: sector 0, start 0, period 0, no blanking
        send(OP_SAMPLE, 12'd4095, 12'd0, 12'd0, 32'd100, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd4095, 12'd4095, 32'd200, 3'd7, 32'hFFFF_FFFF);
        send(OP_SAMPLE, 12'd0, 12'd4095, 12'd4095, 32'd300, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd1, 12'd2048, 12'd4095, 32'hFFFF_FFF0, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd2047, 32'hFFFF_FFF8, 3'd0, 32'd0);
        // index seven wraps to one; falling crossing across the time wrap
        send(OP_COMMUT, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FF00, 3'd7, 32'd1000);
        send(OP_SAMPLE, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FF10, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FF20, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd4095, 12'd0, 32'hFFFF_FF40, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd4094, 12'd0, 12'd0, 32'hFFFF_FF80, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd4094, 12'd5, 12'd0, 32'hFFFF_FFC0, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd4094, 12'd0, 12'd0, 32'h0000_0100, 3'd0, 32'd0);
        // index six wraps to zero; period 1 saturates the bin
        send(OP_COMMUT, 12'd0, 12'd0, 12'd0, 32'd1000, 3'd6, 32'd1);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd0, 32'd1100, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd0, 32'd1200, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd200, 12'd0, 12'd0, 32'd1300, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd3, 32'd1400, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd4095, 32'd3000, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd4095, 32'd4000, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd4095, 32'd5000, 3'd0, 32'd0);
        // diff landing exactly on the deadband edges
        send(OP_COMMUT, 12'd0, 12'd0, 12'd0, 32'd6000, 3'd5, 32'hFFFF_FFFF);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd0, 32'd6100, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd0, 32'd6200, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd8, 12'd0, 12'd0, 32'd6300, 3'd0, 32'd0);
        send(OP_SAMPLE, 12'd0, 12'd0, 12'd16, 32'd6400, 3'd0, 32'd0);

        apply_setting(0, 1, 0, 0, MAX_LVL);
        hold_kick <= 1'b1;
        random_phase(300);
        apply_setting(MAX_LVL, 15, 15, MAX_LVL, 0);
        random_phase(150);
        apply_setting(40, 0, 5, 300, 3800);
        random_phase(300);
        apply_setting($urandom_range(1, 200), $urandom_range(1, 15), $urandom_range(0, 15),
                      $urandom_range(0, MAX_LVL), $urandom_range(0, MAX_LVL));
        random_phase(300);
        apply_setting(16, 15, 0, 100, 4000);
        random_phase(300);
        apply_setting(DEADBAND_RST, CONFIRM_RST, BLANK_RST, SAT_LOW_RST, SAT_HIGH_RST);
        random_phase(150);

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[bemf_zero_cross_detector_unit.f]
hdl/bzcd_pkg.sv
hdl/bzcd_bin_div.sv
hdl/bemf_zero_cross_detector_unit.sv
tb/zero_cross_checker.sv
tb/tb.sv
